### rtl/core/pfn_pkg.sv
// pfn_pkg: shared types, constants and helpers for the fractal Perlin noise core.
// No dependencies.
package pfn_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MX, ST_MY, ST_MZ, ST_CZ,
    ST_F_T2, ST_F_Q, ST_F_T3, ST_F_FD, ST_F_END,
    ST_LOOK, ST_LMUL, ST_LADD, ST_RIDGE, ST_RSQ,
    ST_ACC, ST_NORM, ST_FIN, ST_DONE
  } pfn_state_e;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_EVAL    = 1'b1;
  localparam logic MODE_RIDGED = 1'b1;
  localparam logic REG_BASE_FREQ = 1'b0;

  localparam int unsigned BASE_FREQ_RESET = 65536;
  localparam logic signed [33:0] ONE_Q16  = 34'sd65536;
  localparam logic signed [33:0] FADE_B   = 34'sd983040;   // 15.0 in Q16
  localparam logic signed [21:0] FADE_C   = 22'sd655360;   // 10.0 in Q16

  localparam logic [3:0] LEAF_FIRST = 4'd7;
  localparam logic [3:0] LOOK_LAST  = 4'd14;
  localparam logic [2:0] LERP_LAST  = 3'd6;

  // round(2^32 / (2^k - 1)) for k = 1..16
  localparam logic [32:0] RECIP [16] = '{
    33'd4294967296, 33'd1431655765, 33'd613566757, 33'd286331153,
    33'd138547332,  33'd68174084,   33'd33818640,  33'd16843009,
    33'd8405024,    33'd4198404,    33'd2098177,   33'd1048832,
    33'd524352,     33'd262160,     33'd131076,    33'd65537
  };

  function automatic logic signed [19:0] pfn_grad(input logic [3:0] h,
                                                 input logic signed [17:0] x,
                                                 input logic signed [17:0] y,
                                                 input logic signed [17:0] z);
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic signed [19:0] su;
    logic signed [19:0] sv;
    u  = h[3] ? y : x;
    v  = (h[3:2] == 2'b00) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    su = h[0] ? -20'(u) : 20'(u);
    sv = h[1] ? -20'(v) : 20'(v);
    return su + sv;
  endfunction

endpackage

### rtl/core/pfn_ram.sv
// pfn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/perlin_fractal_noise.sv
// perlin_fractal_noise: fractal / ridged improved 3D Perlin noise on one shared multiplier.
// Depends on pfn_pkg and pfn_ram (permutation table).
//
//  channel   | signals                                  | dir
//  ----------+------------------------------------------+-----
//  input     | in_valid_i/in_ready_o, cmd_i .. mode_i   | in
//  result    | out_valid_o/out_ready_i, noise_value_o   | out
//  config    | psel/penable/pwrite/paddr/pwdata/prdata  | in
//
// Table write: ST_IDLE goes straight to ST_DONE. Evaluate: per octave, map, fade, lookup
// and lerp states (plus ST_RIDGE/ST_RSQ if ridged), then ST_NORM, ST_FIN; all products go
// through one 34x34 multiplier and table reads through the single RAM read port.
// Reset clears control and base_frequency (1.0); the table is unset until written.
// in_ready_o is low from accept until the result transaction completes.
module perlin_fractal_noise import pfn_pkg::*; #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [3:0]         octave_count_i,
  input  logic               mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [18:0] noise_value_o,
  output logic               was_write_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int TW = $clog2(TABLE_SIZE);
  localparam int KW = $clog2(MAX_OCTAVES + 1);
  localparam int OW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int VW = 24;

  pfn_state_e state_q, state_d;

  logic [23:0]         bf_q;
  logic signed [31:0]  cx_q, cy_q, cz_q;
  logic [KW-1:0]       k_q;
  logic [OW-1:0]       oct_q;
  logic                ridged_q;
  logic [TW-1:0]       cell_x_q, cell_y_q, cell_z_q;
  logic [15:0]         fx_q, fy_q, fz_q;
  logic [1:0]          fidx_q;
  logic [15:0]         t2_q;
  logic signed [21:0]  qf_q;
  logic signed [17:0]  fu_q, fv_q, fw_q;
  logic [3:0]          lk_q;
  logic [TW-1:0]       ha_q, hb_q, haa_q, hab_q, hba_q, hbb_q;
  logic signed [VW-1:0] q_q [8];
  logic signed [VW-1:0] q_d [8];
  logic [3:0]          qcnt_q;
  logic [2:0]          lcnt_q;
  logic signed [VW-1:0] term_q;
  logic signed [33:0]  acc_q;
  logic signed [18:0]  noise_q;
  logic                was_write_q;

  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  p_q;

  logic                in_acc, cfg_wr;
  logic [TW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;
  logic [TW-1:0]       rd_cell;
  logic [15:0]         t_sel;
  logic signed [33:0]  t_ext;
  logic signed [67:0]  p_shift;
  logic [2:0]          leaf;
  logic signed [17:0]  gx, gy, gz;
  logic signed [19:0]  grad;
  logic signed [17:0]  wsel;
  logic signed [VW-1:0] lerp_res;
  logic [3:0]          wr_idx;
  logic signed [24:0]  term_abs;
  logic [KW-1:0]       shamt;
  logic                last_oct;
  logic [KW-1:0]       k_in;
  logic signed [35:0]  fin_res;

  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_BASE_FREQ) ? {8'd0, bf_q} : 32'd0;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_DONE);
  assign noise_value_o = noise_q;
  assign was_write_o   = was_write_q;

  pfn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm (
    .clk_i   (clk_i),
    .we_i    (in_acc && (cmd_i == CMD_WRITE)),
    .waddr_i (TW'(table_index_i)),
    .wdata_i (table_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (fidx_q)
      2'd0:    t_sel = fx_q;
      2'd1:    t_sel = fy_q;
      default: t_sel = fz_q;
    endcase
  end
  assign t_ext   = $signed({18'd0, t_sel});
  assign p_shift = p_q <<< oct_q;
  assign rd_cell = TW'(ram_rdata);

  assign leaf = 3'(lk_q - LEAF_FIRST);
  assign gx   = leaf[0] ? $signed({2'b00, fx_q}) - 18'sd65536 : $signed({2'b00, fx_q});
  assign gy   = leaf[1] ? $signed({2'b00, fy_q}) - 18'sd65536 : $signed({2'b00, fy_q});
  assign gz   = leaf[2] ? $signed({2'b00, fz_q}) - 18'sd65536 : $signed({2'b00, fz_q});
  assign grad = pfn_grad(ram_rdata[3:0], gx, gy, gz);

  always_comb begin
    priority if (lcnt_q < 3'd4) begin
      wsel = fu_q;
    end else if (lcnt_q < 3'd6) begin
      wsel = fv_q;
    end else begin
      wsel = fw_q;
    end
  end

  assign lerp_res = q_q[0] + VW'(p_q >>> 16);
  assign wr_idx   = qcnt_q - 4'd2;
  assign term_abs = term_q[VW-1] ? -25'(term_q) : 25'(term_q);
  assign shamt    = k_q - KW'(1) - KW'(oct_q);
  assign last_oct = (KW'(oct_q) == k_q - KW'(1));
  assign fin_res  = 36'(p_q >>> 32);

  always_comb begin
    if (octave_count_i == 4'd0) begin
      k_in = KW'(1);
    end else if ({1'b0, octave_count_i} > 5'(MAX_OCTAVES)) begin
      k_in = KW'(MAX_OCTAVES);
    end else begin
      k_in = KW'(octave_count_i);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = (cmd_i == CMD_WRITE) ? ST_DONE : ST_MX;
      ST_MX:    state_d = ST_MY;
      ST_MY:    state_d = ST_MZ;
      ST_MZ:    state_d = ST_CZ;
      ST_CZ:    state_d = ST_F_T2;
      ST_F_T2:  state_d = ST_F_Q;
      ST_F_Q:   state_d = ST_F_T3;
      ST_F_T3:  state_d = ST_F_FD;
      ST_F_FD:  state_d = ST_F_END;
      ST_F_END: state_d = (fidx_q == 2'd2) ? ST_LOOK : ST_F_T2;
      ST_LOOK:  if (lk_q == LOOK_LAST) state_d = ST_LMUL;
      ST_LMUL:  state_d = ST_LADD;
      ST_LADD: begin
        if (lcnt_q == LERP_LAST) begin
          state_d = ridged_q ? ST_RIDGE : ST_ACC;
        end else begin
          state_d = ST_LMUL;
        end
      end
      ST_RIDGE: state_d = ST_RSQ;
      ST_RSQ:   state_d = ST_ACC;
      ST_ACC:   state_d = last_oct ? ST_NORM : ST_MX;
      ST_NORM:  state_d = ST_FIN;
      ST_FIN:   state_d = ST_DONE;
      ST_DONE:  if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // multiplier operands and table read address
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_raddr = '0;
    unique case (state_q)
      ST_MX: begin
        mul_a = 34'(cx_q);
        mul_b = $signed({10'd0, bf_q});
      end
      ST_MY: begin
        mul_a = 34'(cy_q);
        mul_b = $signed({10'd0, bf_q});
      end
      ST_MZ: begin
        mul_a = 34'(cz_q);
        mul_b = $signed({10'd0, bf_q});
      end
      ST_F_T2: begin
        mul_a = t_ext;
        mul_b = t_ext;
      end
      ST_F_Q: begin
        mul_a = t_ext;
        mul_b = (t_ext <<< 2) + (t_ext <<< 1) - FADE_B;
      end
      ST_F_T3: begin
        mul_a = $signed({18'd0, t2_q});
        mul_b = t_ext;
      end
      ST_F_FD: begin
        mul_a = $signed({18'd0, p_q[31:16]});
        mul_b = 34'(qf_q);
      end
      ST_LOOK: begin
        unique case (lk_q)
          4'd0:    ram_raddr = cell_x_q;
          4'd1:    ram_raddr = cell_x_q + TW'(1);
          4'd2:    ram_raddr = ha_q;
          4'd3:    ram_raddr = ha_q + TW'(1);
          4'd4:    ram_raddr = hb_q;
          4'd5:    ram_raddr = hb_q + TW'(1);
          4'd6:    ram_raddr = haa_q;
          4'd7:    ram_raddr = hba_q;
          4'd8:    ram_raddr = hab_q;
          4'd9:    ram_raddr = hbb_q;
          4'd10:   ram_raddr = haa_q + TW'(1);
          4'd11:   ram_raddr = hba_q + TW'(1);
          4'd12:   ram_raddr = hab_q + TW'(1);
          4'd13:   ram_raddr = hbb_q + TW'(1);
          default: ram_raddr = '0;
        endcase
      end
      ST_LMUL: begin
        mul_a = 34'(wsel);
        mul_b = 34'(q_q[1]) - 34'(q_q[0]);
      end
      ST_RIDGE: begin
        mul_a = ONE_Q16 - 34'(term_abs);
        mul_b = ONE_Q16 - 34'(term_abs);
      end
      ST_NORM: begin
        mul_a = acc_q;
        mul_b = $signed({1'b0, RECIP[4'(k_q - KW'(1))]});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // gradient queue: leaves shift in, lerps consume the head pair
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      q_d[j] = q_q[j];
    end
    if (state_q == ST_LOOK && lk_q >= LEAF_FIRST) begin
      for (int j = 0; j < 7; j++) begin
        q_d[j] = q_q[j + 1];
      end
      q_d[7] = VW'(grad);
    end else if (state_q == ST_LADD) begin
      for (int j = 0; j < 6; j++) begin
        q_d[j] = (4'(j) == wr_idx) ? lerp_res : q_q[j + 2];
      end
      q_d[6] = (wr_idx == 4'd6) ? lerp_res : q_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    for (int j = 0; j < 8; j++) begin
      q_q[j] <= q_d[j];
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd_i == CMD_EVAL) begin
          cx_q     <= coord_x_i;
          cy_q     <= (mode_i == MODE_RIDGED) ? 32'sd0 : coord_y_i;
          cz_q     <= coord_z_i;
          ridged_q <= (mode_i == MODE_RIDGED);
          acc_q    <= '0;
        end
      end
      ST_MY: begin
        cell_x_q <= p_shift[32 +: TW];
        fx_q     <= p_shift[31:16];
      end
      ST_MZ: begin
        cell_y_q <= p_shift[32 +: TW];
        fy_q     <= p_shift[31:16];
      end
      ST_CZ: begin
        cell_z_q <= p_shift[32 +: TW];
        fz_q     <= p_shift[31:16];
      end
      ST_F_Q:  t2_q <= p_q[31:16];
      ST_F_T3: qf_q <= 22'(p_q >>> 16) + FADE_C;
      ST_F_END: begin
        unique case (fidx_q)
          2'd0:    fu_q <= 18'(p_q >>> 16);
          2'd1:    fv_q <= 18'(p_q >>> 16);
          default: fw_q <= 18'(p_q >>> 16);
        endcase
      end
      ST_LOOK: begin
        unique case (lk_q)
          4'd1:    ha_q  <= rd_cell + cell_y_q;
          4'd2:    hb_q  <= rd_cell + cell_y_q;
          4'd3:    haa_q <= rd_cell + cell_z_q;
          4'd4:    hab_q <= rd_cell + cell_z_q;
          4'd5:    hba_q <= rd_cell + cell_z_q;
          4'd6:    hbb_q <= rd_cell + cell_z_q;
          default: ;
        endcase
      end
      ST_LADD: begin
        if (lcnt_q == LERP_LAST) term_q <= lerp_res;
      end
      ST_RSQ: term_q <= VW'(p_q >>> 16);
      ST_ACC: acc_q  <= acc_q + (34'(term_q) <<< shamt);
      ST_FIN: begin
        if (fin_res > 36'sd262143) begin
          noise_q <= 19'sd262143;
        end else if (fin_res < -36'sd262144) begin
          noise_q <= -19'sd262144;
        end else begin
          noise_q <= 19'(fin_res);
        end
      end
      default: ;
    endcase
    if (state_q == ST_IDLE && in_acc) begin
      was_write_q <= (cmd_i == CMD_WRITE);
      if (cmd_i == CMD_WRITE) noise_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bf_q    <= 24'(BASE_FREQ_RESET);
      k_q     <= KW'(1);
      oct_q   <= '0;
      fidx_q  <= '0;
      lk_q    <= '0;
      lcnt_q  <= '0;
      qcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr[2] == REG_BASE_FREQ) bf_q <= pwdata[23:0];
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            k_q   <= k_in;
            oct_q <= '0;
          end
        end
        ST_CZ:    fidx_q <= '0;
        ST_F_END: begin
          fidx_q <= fidx_q + 2'd1;
          lk_q   <= '0;
        end
        ST_LOOK: begin
          lk_q   <= lk_q + 4'd1;
          qcnt_q <= 4'd8;
          lcnt_q <= '0;
        end
        ST_LADD: begin
          lcnt_q <= lcnt_q + 3'd1;
          qcnt_q <= qcnt_q - 4'd1;
        end
        ST_ACC: begin
          if (!last_oct) oct_q <= oct_q + OW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/pfn_checker.sv
// pfn_checker: port-level assertions for perlin_fractal_noise, bound to the top level.
// Depends on nothing beyond the ports of perlin_fractal_noise.
module pfn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [18:0] noise_value_o,
  input logic               was_write_o
);

  // result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("result dropped while stalled");

  // no new transaction while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");

  // busy right after an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // table write acknowledge carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_write_o |-> noise_value_o == 19'sd0)
    else $error("nonzero value on write acknowledge");

endmodule

bind perlin_fractal_noise pfn_checker u_pfn_checker (.*);

### sim/testbench.sv
// Testbench for perlin_fractal_noise: table loads and fractal/ridged noise evaluations
// checked against a built-in fixed-point noise predictor. Depends on pfn_pkg and the RTL.
`timescale 1ns / 1ps

module testbench import pfn_pkg::*; ();

  typedef struct {
    logic signed [18:0] noise_value;
    logic               was_write;
  } noise_res_t;

  class noise_scoreboard;
    logic [7:0]  perm [256];
    logic [23:0] base_freq;
    noise_res_t  pending [$];
    int          errors;

    function new();
      for (int i = 0; i < 256; i++) perm[i] = 8'd0;
      base_freq = 24'd65536;
      errors = 0;
    endfunction

    function longint fshr(longint v, int n);
      return v >>> n;
    endfunction

    function longint fade(longint t);
      longint t2, t3, q;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      q = fshr(t * (6 * t - 15 * 65536), 16) + 10 * 65536;
      return fshr(t3 * q, 16);
    endfunction

    function longint lerp(longint w, longint a, longint b);
      return a + fshr(w * (b - a), 16);
    endfunction

    function longint grad(logic [7:0] hh, longint x, longint y, longint z);
      logic [3:0] h;
      longint u, v;
      h = hh[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function void split_coord(logic [31:0] c, logic [63:0] f, output logic [7:0] cidx,
                              output longint frac);
      logic [63:0] p;
      p = {{32{c[31]}}, c} * f;
      frac = longint'(p[31:16]);
      cidx = p[39:32];
    endfunction

    function longint lk(int i);
      return longint'(perm[i & 255]);
    endfunction

    function longint octave_noise(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                  logic [63:0] f);
      logic [7:0] xc, yc, zc;
      longint x, y, z, u, v, w, x1, y1, z1;
      int a, b, aa, ab, ba, bb;
      split_coord(cx, f, xc, x);
      split_coord(cy, f, yc, y);
      split_coord(cz, f, zc, z);
      u = fade(x); v = fade(y); w = fade(z);
      x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
      a = int'(lk(xc)) + yc; aa = int'(lk(a)) + zc; ab = int'(lk(a + 1)) + zc;
      b = int'(lk(xc + 1)) + yc; ba = int'(lk(b)) + zc; bb = int'(lk(b + 1)) + zc;
      return lerp(w,
        lerp(v, lerp(u, grad(lk(aa), x, y, z), grad(lk(ba), x1, y, z)),
                lerp(u, grad(lk(ab), x, y1, z), grad(lk(bb), x1, y1, z))),
        lerp(v, lerp(u, grad(lk(aa + 1), x, y, z1), grad(lk(ba + 1), x1, y, z1)),
                lerp(u, grad(lk(ab + 1), x, y1, z1), grad(lk(bb + 1), x1, y1, z1))));
    endfunction

    function void note_input(logic cmd, logic [7:0] idx, logic [7:0] val,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [3:0] oct, logic md);
      noise_res_t r;
      int k;
      longint acc, n, rr, res;
      logic [63:0] d, rec;
      if (cmd == CMD_WRITE) begin
        perm[idx] = val;
        r.noise_value = '0;
        r.was_write = 1'b1;
        pending = {pending, r};
        return;
      end
      k = (oct == 0) ? 1 : ((oct > 8) ? 8 : oct);
      if (md == MODE_RIDGED) cy = '0;
      acc = 0;
      for (int i = 0; i < k; i++) begin
        n = octave_noise(cx, cy, cz, 64'(base_freq) << i);
        if (md == MODE_RIDGED) begin
          rr = 65536 - ((n < 0) ? -n : n);
          n = (rr * rr) >>> 16;
        end
        acc += n * (longint'(1) << (k - 1 - i));
      end
      d = (64'd1 << k) - 1;
      rec = ((64'd1 << 32) + (d >> 1)) / d;
      res = fshr(acc * longint'(rec), 32);
      if (res > 262143) res = 262143;
      if (res < -262144) res = -262144;
      r.noise_value = res[18:0];
      r.was_write = 1'b0;
      pending = {pending, r};
    endfunction

    function void check_result(logic signed [18:0] nv, logic ww);
      noise_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result noise=%0d was_write=%0b", $time, nv, ww);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (nv !== e.noise_value) begin
        $display("%0t: noise_value expected %0d actual %0d", $time, e.noise_value, nv);
        errors++;
      end
      if (ww !== e.was_write) begin
        $display("%0t: was_write expected %0b actual %0b", $time, e.was_write, ww);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, cmd_i, mode_i;
  logic [7:0] table_index_i, table_value_i;
  logic signed [31:0] coord_x_i, coord_y_i, coord_z_i;
  logic [3:0] octave_count_i;
  logic out_valid_o, out_ready_i, was_write_o;
  logic signed [18:0] noise_value_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  noise_scoreboard sb;
  int hold_off;
  bit all_sent;

  perlin_fractal_noise dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send(logic cmd, logic [7:0] idx, logic [7:0] val, logic [31:0] cx,
                      logic [31:0] cy, logic [31:0] cz, logic [3:0] oct, logic md);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= cmd; table_index_i <= idx; table_value_i <= val;
    coord_x_i <= cx; coord_y_i <= cy; coord_z_i <= cz;
    octave_count_i <= oct; mode_i <= md; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, idx, val, cx, cy, cz, oct, md);
  endtask

  task automatic load_entry(int i, int v);
    send(CMD_WRITE, i[7:0], v[7:0], $urandom, $urandom, $urandom, 4'($urandom),
         1'($urandom));
  endtask

  task automatic evaluate(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [3:0] oct, logic md);
    send(CMD_EVAL, 8'($urandom), 8'($urandom), cx, cy, cz, oct, md);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_freq(logic [23:0] f);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_BASE_FREQ, 2'b00}; pwdata <= {8'd0, f};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.base_freq = f;
  endtask

  task automatic random_eval();
    logic [31:0] c [3];
    logic [3:0] oct;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 3))
        0: c[j] = $urandom;
        1: c[j] = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        2: c[j] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        default: c[j] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
    end
    oct = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(1, 3));
    evaluate(c[0], c[1], c[2], oct, 1'($urandom));
  endtask

  initial begin
    int wait_cycles;
    out_ready_i = 1'b0;
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      wait_cycles = $urandom_range(0, 6);
      if (wait_cycles != 0 || hold_off > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
        while (hold_off > 0) begin
          @(posedge clk_i);
          hold_off--;
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(noise_value_o, was_write_o);
    end
  end

  initial begin
    logic [23:0] freqs [5];
    freqs = '{24'hFFFFFF, 24'd0, 24'd1, 24'd32768, 24'($urandom)};
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 0; cmd_i = 0; table_index_i = 0; table_value_i = 0;
    coord_x_i = 0; coord_y_i = 0; coord_z_i = 0; octave_count_i = 1; mode_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole table before any evaluation reads it
    for (int i = 0; i < 256; i++) load_entry(i, $urandom_range(0, 255));
    load_entry(0, 255);
    load_entry(255, 0);
    evaluate(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd1, 1'b0);
    evaluate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd8, 1'b0);
    evaluate(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'd8, 1'b1);
    evaluate(32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFF_0000, 4'd0, 1'b0);
    evaluate(32'h0000_8000, 32'hFFFF_8000, 32'h0000_FFFF, 4'd15, 1'b1);
    evaluate(32'h0012_3456, 32'h0000_7FFF, 32'hFFF0_0001, 4'd9, 1'b0);
    evaluate(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 4'd4, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_freq(freqs[p]);
      for (int n = 0; n < 100; n++) random_eval();
      drain();
    end
    write_freq(24'd65536);

    hold_off = 300;
    for (int n = 0; n < 20; n++) random_eval();
    drain();

    for (int n = 0; n < 1200; n++) begin
      if ($urandom_range(0, 9) == 0) load_entry($urandom, $urandom);
      else random_eval();
    end
    drain();

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
